// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent holds, consequent holds in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent holds, consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/lrt_pkg.sv -----
// Types and codes shared by the LRU tracker modules.
`default_nettype none
package lrt_pkg;

  localparam int KEY_W = 64;

  // Request codes.
  localparam logic [1:0] REQ_TOUCH  = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_EVICT  = 2'd2;

  // Outcome codes.
  localparam logic [1:0] OUT_DONE  = 2'd0;
  localparam logic [1:0] OUT_EMPTY = 2'd1;
  localparam logic [1:0] OUT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] chunk_key;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0] victim_key;
    logic [1:0]       outcome;
    logic             was_present;
  } rsp_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;      // compare cycle: capture the match flag
    logic lookup;    // match on key equality
    logic tail_sel;  // match on the least recent valid slot
    logic upd_ins;   // insert: every slot takes its upper neighbor
    logic upd_mv;    // move to front: slots down to the match shift
    logic upd_rm;    // removal: slots from the match take the lower neighbor
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/lrt_cell.sv -----
// One slot of the recency list: a key, its valid bit and a match flag.
`default_nettype none
module lrt_cell #(
  parameter int KEY_BITS = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire lrt_pkg::cell_ctl_t  ctl,
  input  wire  [KEY_BITS-1:0]      req_key,
  input  wire  [KEY_BITS-1:0]      key_prev,
  input  wire                      valid_prev,
  input  wire  [KEY_BITS-1:0]      key_next,
  input  wire                      valid_next,
  input  wire                      seen_in,
  input  wire  [KEY_BITS-1:0]      vict_in,
  output logic [KEY_BITS-1:0]      key_o,
  output logic                     valid_o,
  output logic                     match_o,
  output logic                     seen_out,
  output logic [KEY_BITS-1:0]      vict_out
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                valid_r, valid_nxt;
  logic                match_r, match_nxt;

  // Match flag is captured in the compare cycle and held through the update.
  always_comb begin
    match_nxt = match_r;
    if (ctl.load) begin
      if (ctl.lookup) begin
        match_nxt = valid_r && (key_r == req_key);
      end else if (ctl.tail_sel) begin
        match_nxt = valid_r && !valid_next;
      end else begin
        match_nxt = 1'b0;
      end
    end
  end

  // Slot update: shift toward the least recent end, or close a gap.
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctl.upd_ins || (ctl.upd_mv && !seen_in)) begin
      key_nxt   = key_prev;
      valid_nxt = valid_prev;
    end else if (ctl.upd_rm && (seen_in || match_r)) begin
      key_nxt   = key_next;
      valid_nxt = valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // Neighbor chain: whether a match lies at or above this slot, and its key.
  assign seen_out = seen_in || match_r;
  assign vict_out = match_r ? key_r : vict_in;
  assign key_o    = key_r;
  assign valid_o  = valid_r;
  assign match_o  = match_r;

endmodule
`default_nettype wire

// ----- hdl/lru_replacement_tracker.sv -----
// Top level of the LRU replacement tracker: sequencer and the row of slot cells.
`default_nettype none
`include "assert_macros.svh"
// A request is taken when start is high and busy is low. Each request runs as
// a compare cycle, in which every cell checks its key against the request (busy
// is high), and an update cycle, in which the match flag ripples along the row of
// CAPACITY cells and every slot shifts in the same edge. A new request can be
// taken at the end of the update cycle, so the block does not take a new request
// while one is in its compare cycle. The result is registered from the update
// cycle, appears on out_rsp with out_valid for exactly one cycle, and must be
// taken then; the receiver cannot stall it. Slot 0 holds the most recently used key.
module lru_replacement_tracker #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire lrt_pkg::req_t   in_req,
  output logic                 out_valid,
  output lrt_pkg::rsp_t        out_rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          req_type_r;
  logic [KEY_BITS-1:0] req_key_r;
  logic                out_valid_r, out_valid_nxt;
  lrt_pkg::rsp_t       rsp_r, rsp_nxt;
  lrt_pkg::cell_ctl_t  ctl;
  logic                accept;

  logic [KEY_BITS-1:0] cell_key  [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY:0]   seen_c;
  logic [KEY_BITS-1:0] vict_c    [CAPACITY+1];
  logic                hit, full;
  logic [lrt_pkg::KEY_W-1:0] vict_ext;

  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;

  // Sequencer: compare, then update; a new request may enter on the update edge.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture; key bits above KEY_BITS are dropped here.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req.req_type;
      req_key_r  <= in_req.chunk_key[KEY_BITS-1:0];
    end
    rsp_r <= rsp_nxt;
  end

  assign hit  = seen_c[CAPACITY];
  assign full = valid_vec[CAPACITY-1];

  // Control broadcast to the cells.
  always_comb begin
    ctl          = '0;
    ctl.load     = (state_r == S_CMP);
    ctl.lookup   = (req_type_r == lrt_pkg::REQ_TOUCH) || (req_type_r == lrt_pkg::REQ_REMOVE);
    ctl.tail_sel = (req_type_r == lrt_pkg::REQ_EVICT);
    if (state_r == S_UPD) begin
      ctl.upd_mv  = (req_type_r == lrt_pkg::REQ_TOUCH) && hit;
      ctl.upd_ins = (req_type_r == lrt_pkg::REQ_TOUCH) && !hit && !full;
      ctl.upd_rm  = ((req_type_r == lrt_pkg::REQ_REMOVE) ||
                     (req_type_r == lrt_pkg::REQ_EVICT)) && hit;
    end
  end

  // Row of slot cells.
  assign seen_c[0] = 1'b0;
  assign vict_c[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] kp, kn;
    logic                vp, vn;
    if (i == 0) begin : g_head
      assign kp = req_key_r;
      assign vp = 1'b1;
    end else begin : g_body
      assign kp = cell_key[i-1];
      assign vp = valid_vec[i-1];
    end
    if (i == CAPACITY-1) begin : g_tail
      assign kn = '0;
      assign vn = 1'b0;
    end else begin : g_inner
      assign kn = cell_key[i+1];
      assign vn = valid_vec[i+1];
    end
    lrt_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .req_key   (req_key_r),
      .key_prev  (kp),
      .valid_prev(vp),
      .key_next  (kn),
      .valid_next(vn),
      .seen_in   (seen_c[i]),
      .vict_in   (vict_c[i]),
      .key_o     (cell_key[i]),
      .valid_o   (valid_vec[i]),
      .match_o   (match_vec[i]),
      .seen_out  (seen_c[i+1]),
      .vict_out  (vict_c[i+1])
    );
  end

  always_comb begin
    vict_ext                = '0;
    vict_ext[KEY_BITS-1:0]  = vict_c[CAPACITY];
  end

  // Result formed in the update cycle and registered for one strobe cycle.
  always_comb begin
    out_valid_nxt = (state_r == S_UPD);
    rsp_nxt       = '0;
    case (req_type_r)
      lrt_pkg::REQ_TOUCH: begin
        rsp_nxt.was_present = hit;
        rsp_nxt.outcome     = (!hit && full) ? lrt_pkg::OUT_FULL : lrt_pkg::OUT_DONE;
      end
      lrt_pkg::REQ_REMOVE: begin
        rsp_nxt.was_present = hit;
      end
      lrt_pkg::REQ_EVICT: begin
        rsp_nxt.outcome    = hit ? lrt_pkg::OUT_DONE : lrt_pkg::OUT_EMPTY;
        rsp_nxt.victim_key = hit ? vict_ext : '0;
      end
      default: rsp_nxt = '0;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // Checks on sequencing and on the shape of the list.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `ASSERT_NEXT(a_busy_one_cycle, clk, rst_n, busy, !busy)
  `ASSERT_IMPLY(a_upd_one_match, clk, rst_n, state_r == S_UPD, $onehot0(match_vec))
  `ASSERT_IMPLY(a_valid_packed, clk, rst_n, 1'b1,
                (valid_vec & (valid_vec + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0)

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the LRU replacement tracker.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 16;
  localparam int KBITS = 64;
  localparam int KEY_W = lrt_pkg::KEY_W;
  localparam int RANDOM_ITEMS = 1324;
  localparam int CYCLE_LIMIT = 100000;
  localparam int POOL_SIZE = 24;

  // Request code that the block treats as no operation.
  localparam logic [1:0] REQ_NOP = 2'd3;

  // Scoreboard: keeps its own recency list and the queue of expected results.
  class lru_scoreboard;
    logic [KEY_W-1:0] recency[CAP];
    int unsigned listed;
    lrt_pkg::rsp_t pending_rsp[$];
    int unsigned failures;

    function new();
      listed = 0;
      failures = 0;
      foreach (recency[i]) recency[i] = '0;
    endfunction

    function logic [KEY_W-1:0] key_mask();
      logic [KEY_W-1:0] m;
      m = '1;
      if (KBITS < KEY_W) m = (KEY_W'(1) << KBITS) - 1;
      return m;
    endfunction

    function int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < CAP; i++)
        if (i < listed && recency[i] == key) return i;
      return -1;
    endfunction

    // Close the gap at pos by pulling the less recent keys up one slot.
    function void drop_slot(int pos);
      for (int i = pos; i + 1 < listed; i++) recency[i] = recency[i+1];
      listed--;
      recency[listed] = '0;
    endfunction

    function void push_front(logic [KEY_W-1:0] key);
      for (int i = listed; i > 0; i--) recency[i] = recency[i-1];
      recency[0] = key;
      listed++;
    endfunction

    // Work out the result of one accepted transaction and queue it.
    function void note_request(lrt_pkg::req_t r);
      lrt_pkg::rsp_t e;
      logic [KEY_W-1:0] key;
      int pos;
      e = '0;
      e.outcome = lrt_pkg::OUT_DONE;
      key = r.chunk_key & key_mask();
      pos = find_slot(key);
      case (r.req_type)
        lrt_pkg::REQ_TOUCH: begin
          if (pos >= 0) begin
            e.was_present = 1'b1;
            drop_slot(pos);
            push_front(key);
          end else if (listed == CAP) begin
            e.outcome = lrt_pkg::OUT_FULL;
          end else begin
            push_front(key);
          end
        end
        lrt_pkg::REQ_REMOVE: begin
          if (pos >= 0) begin
            e.was_present = 1'b1;
            drop_slot(pos);
          end
        end
        lrt_pkg::REQ_EVICT: begin
          if (listed == 0) begin
            e.outcome = lrt_pkg::OUT_EMPTY;
          end else begin
            e.victim_key = recency[listed-1];
            drop_slot(listed - 1);
          end
        end
        default: e = '0;
      endcase
      pending_rsp.push_back(e);
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    // Compare one result with the oldest expectation.
    function void check_response(lrt_pkg::rsp_t got);
      lrt_pkg::rsp_t e;
      if (pending_rsp.size() == 0) begin
        report($sformatf("result with nothing expected: victim %h outcome %0d present %0b",
                         got.victim_key, got.outcome, got.was_present));
        return;
      end
      e = pending_rsp.pop_front();
      if (got.victim_key !== e.victim_key || got.outcome !== e.outcome ||
          got.was_present !== e.was_present)
        report($sformatf("mismatch: expected victim %h outcome %0d present %0b, got %h %0d %0b",
                         e.victim_key, e.outcome, e.was_present,
                         got.victim_key, got.outcome, got.was_present));
    endfunction

    function void check_drained();
      if (pending_rsp.size() != 0)
        report($sformatf("%0d results never arrived", pending_rsp.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  lrt_pkg::req_t in_req = '0;
  logic busy;
  logic out_valid;
  lrt_pkg::rsp_t out_rsp;

  lru_scoreboard sb = new();
  int unsigned cycles = 0;
  int idle_pct = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  lru_replacement_tracker #(.CAPACITY(CAP), .KEY_BITS(KBITS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  always #4 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Every result strobe is a transaction; the receiver never stalls it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_response(out_rsp);
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Drive one transaction, optionally after an idle gap, and wait until it is taken.
  task automatic send_req(input logic [1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    start <= 1'b1;
    in_req <= '{req_type: op, chunk_key: key};
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request('{req_type: op, chunk_key: key});
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Random traffic; the touch share is drawn anew every 40 items so the
  // list swings between empty and full.
  task automatic random_phase(input int count);
    int touch_pct;
    int roll;
    logic [1:0] op;
    logic [KEY_W-1:0] key;
    touch_pct = 55;
    foreach (key_pool[i]) key_pool[i] = rand_key();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: touch_pct = 85;
          1: touch_pct = 55;
          default: touch_pct = 30;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) op = REQ_NOP;
      else if (roll < touch_pct) op = lrt_pkg::REQ_TOUCH;
      else if (roll < touch_pct + (100 - touch_pct) / 2) op = lrt_pkg::REQ_REMOVE;
      else op = lrt_pkg::REQ_EVICT;
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = rand_key();
      send_req(op, key);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty list, unused code, extreme keys, hits and misses.
    send_req(lrt_pkg::REQ_EVICT, rand_key());
    send_req(REQ_NOP, rand_key());
    send_req(lrt_pkg::REQ_TOUCH, '0);
    send_req(lrt_pkg::REQ_TOUCH, '1);
    send_req(lrt_pkg::REQ_TOUCH, '0);
    send_req(lrt_pkg::REQ_REMOVE, 64'h5555_5555_5555_5555);
    send_req(lrt_pkg::REQ_REMOVE, '1);
    send_req(lrt_pkg::REQ_EVICT, '1);
    // Fill the list to capacity, then a new key is dropped and a listed one is not.
    for (int i = 1; i <= CAP; i++)
      send_req(lrt_pkg::REQ_TOUCH,
               (i % 2) ? {32'hAAAA_AAAA, 32'(i)} : {32'h5555_5555, 32'(i)});
    send_req(lrt_pkg::REQ_TOUCH, 64'hFEDC_BA98_7654_3210);
    send_req(lrt_pkg::REQ_TOUCH, {32'hAAAA_AAAA, 32'd1});
    drain();

    // Random part in phases of different sender idling.
    idle_pct = 0;
    random_phase(RANDOM_ITEMS / 4);
    drain();
    idle_pct = 75;
    random_phase(RANDOM_ITEMS / 4);
    drain();
    idle_pct = 0;
    random_phase(RANDOM_ITEMS / 4);
    idle_pct = 21;
    random_phase(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4));

    drain();
    repeat (8) @(posedge clk);
    sb.check_drained();
    if (sb.failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- lru_replacement_tracker.f -----
+incdir+hdl
hdl/lrt_pkg.sv
hdl/lrt_cell.sv
hdl/lru_replacement_tracker.sv
dv/tb.sv
